// File: rtl/core/cal_step_pkg.sv
// Types, operation codes and calendar helper functions for the date-time stepper.
// Depends on nothing; the stepper top level imports it.
`default_nettype none

package cal_step_pkg;

	// Operation codes carried on the op field of an input transaction.
	typedef enum logic [2:0] {
		OP_MIN_NEXT  = 3'd0,
		OP_MIN_PREV  = 3'd1,
		OP_HOUR_NEXT = 3'd2,
		OP_HOUR_PREV = 3'd3,
		OP_DAY_NEXT  = 3'd4,
		OP_DAY_PREV  = 3'd5,
		OP_MON_NEXT  = 3'd6,
		OP_MON_PREV  = 3'd7
	} op_t;

	// One date-time at the widths of the ports.
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} date_t;

	localparam logic [5:0] MINUTE_TOP = 6'd59;
	localparam logic [4:0] HOUR_TOP   = 5'd23;
	localparam logic [3:0] MONTH_TOP  = 4'd12;
	localparam logic [3:0] MONTH_SPAN = 4'd11;

	// Exact quotient by 25 for any 16-bit value: (y * DIV25_RECIP) >> DIV25_SHIFT.
	localparam logic [16:0] DIV25_RECIP = 17'd83887;
	localparam int          DIV25_SHIFT = 21;
	localparam int          QUOT_W      = 12;

	// Days in a month; zero marks a month outside 1 to 12.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] n;
		begin
			unique case (month)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
				4'd2:                                       n = leap ? 5'd29 : 5'd28;
				default:                                    n = 5'd0;
			endcase
			return n;
		end
	endfunction

	// Month one later; at or past December it folds back by eleven.
	function automatic logic [3:0] month_next(input logic [3:0] month);
		begin
			return (month >= MONTH_TOP) ? month - MONTH_SPAN : month + 4'd1;
		end
	endfunction

	// Month one earlier; at or below January it folds up by eleven.
	function automatic logic [3:0] month_prev(input logic [3:0] month);
		begin
			return (month <= 4'd1) ? month + MONTH_SPAN : month - 4'd1;
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/calendar_minute_hour_day_stepper.sv
// Pipeline: four register stages (s1 to s4); a transaction passes them in order and its
// result is driven from s4, which holds it while out_stall is high.
// Throughput: one transaction per cycle while out_stall does not hold the pipeline; the
// leap-year test, the month-length lookup and the year carry each sit in their own stage.
// Reset: arst_n clears all stage valid bits at once; payload registers are not reset.
// Gregorian date-time stepper top level; imports cal_step_pkg for types and helpers.
`default_nettype none

module calendar_minute_hour_day_stepper
	import cal_step_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  op,
	input  wire  [15:0] year_in,
	input  wire  [3:0]  month_in,
	input  wire  [4:0]  day_in,
	input  wire  [4:0]  hour_in,
	input  wire  [5:0]  minute_in,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic        bad_month
);

	// Stage valid bits and per-stage load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !valid_s4 || !out_stall;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 1 input logic: decode the operation, step minute and hour, start the
	// divide-by-25 for the leap-year test.
	date_t                   src_in;
	logic                    back_in, do_day_in, do_mon_in;
	logic                    carry_h, carry_d;
	logic [5:0]              min_new;
	logic [4:0]              hour_new;
	logic [32:0]             prod_in;
	logic [QUOT_W-1:0]       quot_in;

	assign src_in  = '{year: year_in, month: month_in, day: day_in, hour: hour_in,
		minute: minute_in};
	assign prod_in = 33'(year_in) * 33'(DIV25_RECIP);
	assign quot_in = prod_in[DIV25_SHIFT +: QUOT_W];

	always_comb begin
		logic is_min, is_hour;
		is_min    = 1'b0;
		is_hour   = 1'b0;
		do_day_in = 1'b0;
		do_mon_in = 1'b0;
		back_in   = 1'b0;
		unique case (op_t'(op))
			OP_MIN_NEXT:  is_min = 1'b1;
			OP_MIN_PREV: begin
				is_min  = 1'b1;
				back_in = 1'b1;
			end
			OP_HOUR_NEXT: is_hour = 1'b1;
			OP_HOUR_PREV: begin
				is_hour = 1'b1;
				back_in = 1'b1;
			end
			OP_DAY_NEXT:  do_day_in = 1'b1;
			OP_DAY_PREV: begin
				do_day_in = 1'b1;
				back_in   = 1'b1;
			end
			OP_MON_NEXT:  do_mon_in = 1'b1;
			OP_MON_PREV: begin
				do_mon_in = 1'b1;
				back_in   = 1'b1;
			end
			default:      do_mon_in = 1'b1;
		endcase

		// Minute step, carrying or borrowing into the hour.
		min_new = minute_in;
		carry_h = is_hour;
		if (is_min) begin
			if (!back_in) begin
				if (minute_in >= MINUTE_TOP) begin
					min_new = minute_in - MINUTE_TOP;
					carry_h = 1'b1;
				end else begin
					min_new = minute_in + 6'd1;
				end
			end else begin
				if (minute_in == 6'd0) begin
					min_new = MINUTE_TOP;
					carry_h = 1'b1;
				end else begin
					min_new = minute_in - 6'd1;
				end
			end
		end

		// Hour step, carrying or borrowing into the day.
		hour_new = hour_in;
		carry_d  = 1'b0;
		if (carry_h) begin
			if (!back_in) begin
				if (hour_in >= HOUR_TOP) begin
					hour_new = hour_in - HOUR_TOP;
					carry_d  = 1'b1;
				end else begin
					hour_new = hour_in + 5'd1;
				end
			end else begin
				if (hour_in == 5'd0) begin
					hour_new = HOUR_TOP;
					carry_d  = 1'b1;
				end else begin
					hour_new = hour_in - 5'd1;
				end
			end
		end
		do_day_in = do_day_in || carry_d;
	end

	date_t             src_s1;
	logic [5:0]        min_s1;
	logic [4:0]        hour_s1;
	logic              back_s1, do_day_s1, do_mon_s1;
	logic [QUOT_W-1:0] quot_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			src_s1    <= src_in;
			min_s1    <= min_new;
			hour_s1   <= hour_new;
			back_s1   <= back_in;
			do_day_s1 <= do_day_in;
			do_mon_s1 <= do_mon_in;
			quot_s1   <= quot_in;
		end
	end

	// Stage 2: finish the leap-year test and choose the month whose length is needed.
	logic [15:0] q25;
	logic        div25, leap_nx, borrow_nx;
	logic [3:0]  lookup_nx;

	assign q25       = {quot_s1, 4'b0000} + 16'({quot_s1, 3'b000}) + 16'(quot_s1);
	assign div25     = (q25 == src_s1.year);
	assign leap_nx   = (src_s1.year[1:0] == 2'b00) && (!div25 || src_s1.year[3:0] == 4'd0);
	assign borrow_nx = back_s1 && (src_s1.day <= 5'd1);
	assign lookup_nx = borrow_nx ? month_prev(src_s1.month) : src_s1.month;

	date_t      src_s2;
	logic [5:0] min_s2;
	logic [4:0] hour_s2;
	logic       back_s2, do_day_s2, do_mon_s2, leap_s2, borrow_s2;
	logic [3:0] lookup_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			src_s2    <= src_s1;
			min_s2    <= min_s1;
			hour_s2   <= hour_s1;
			back_s2   <= back_s1;
			do_day_s2 <= do_day_s1;
			do_mon_s2 <= do_mon_s1;
			leap_s2   <= leap_nx;
			borrow_s2 <= borrow_nx;
			lookup_s2 <= lookup_nx;
		end
	end

	// Stage 3: month-length lookup and the day step.
	logic [4:0] mdays;
	logic [4:0] day_nx;
	logic       fail_nx, mstep_nx;

	assign mdays = month_days(lookup_s2, leap_s2);

	always_comb begin
		day_nx   = src_s2.day;
		mstep_nx = do_mon_s2;
		fail_nx  = 1'b0;
		if (do_day_s2) begin
			if (!back_s2) begin
				fail_nx = (mdays == 5'd0);
				if (src_s2.day >= mdays) begin
					day_nx   = src_s2.day - (mdays - 5'd1);
					mstep_nx = 1'b1;
				end else begin
					day_nx = src_s2.day + 5'd1;
				end
			end else if (borrow_s2) begin
				fail_nx  = (mdays == 5'd0);
				day_nx   = src_s2.day + (mdays - 5'd1);
				mstep_nx = 1'b1;
			end else begin
				day_nx = src_s2.day - 5'd1;
			end
		end
	end

	date_t      src_s3;
	logic [5:0] min_s3;
	logic [4:0] hour_s3;
	logic [4:0] day_s3;
	logic       back_s3, do_day_s3, fail_s3, mstep_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			src_s3    <= src_s2;
			min_s3    <= min_s2;
			hour_s3   <= hour_s2;
			day_s3    <= day_nx;
			back_s3   <= back_s2;
			do_day_s3 <= do_day_s2;
			fail_s3   <= fail_nx;
			mstep_s3  <= mstep_nx;
		end
	end

	// Stage 4: month step with year carry or borrow, then the error echo.
	date_t res_nx;

	always_comb begin
		res_nx = '{year: src_s3.year, month: src_s3.month, day: day_s3, hour: hour_s3,
			minute: min_s3};
		if (mstep_s3) begin
			if (back_s3) begin
				res_nx.month = month_prev(src_s3.month);
				if (src_s3.month <= 4'd1) begin
					res_nx.year = src_s3.year - 16'd1;
				end
			end else begin
				res_nx.month = month_next(src_s3.month);
				if (src_s3.month >= MONTH_TOP) begin
					res_nx.year = src_s3.year + 16'd1;
				end
			end
		end
		if (fail_s3) begin
			res_nx = src_s3;
		end
	end

	date_t res_s4;
	logic  bad_s4, do_day_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			res_s4    <= res_nx;
			bad_s4    <= fail_s3;
			do_day_s4 <= do_day_s3;
		end
	end

	// Output transaction.
	assign out_valid  = valid_s4;
	assign year_out   = res_s4.year;
	assign month_out  = res_s4.month;
	assign day_out    = res_s4.day;
	assign hour_out   = res_s4.hour;
	assign minute_out = res_s4.minute;
	assign bad_month  = bad_s4;

`ifndef ASSERT_OFF
	// A failed lookup only comes from a month outside 1 to 12, which is echoed on month_out.
	a_bad_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && bad_month) |-> (month_out == 4'd0 || month_out > MONTH_TOP))
		else $error("bad_month raised for a month inside the calendar range");

	// A successful day step never lands on day zero.
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && do_day_s4 && !bad_s4) |-> (day_out != 5'd0))
		else $error("day step produced day zero");

	// An accepted transaction occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction did not reach stage 1");

	// A stage that cannot advance keeps its transaction intact.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy_s3) |=> (valid_s2 && $stable(src_s2) && $stable(lookup_s2)))
		else $error("stage 2 transaction changed while stalled");
`endif

endmodule

`default_nettype wire

// File: tb/calendar_minute_hour_day_stepper_test.sv
// Self-checking testbench for calendar_minute_hour_day_stepper: a directed table, then random
// date-times, each checked against a typed result or the behavioral stepper in this file.
// Depends on cal_step_pkg for the operation codes and the date_t layout.
`timescale 1ns / 100ps

module calendar_minute_hour_day_stepper_test;
	import cal_step_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int FLOOD_AT     = 400;
	localparam int FLOOD_ITEMS  = 64;
	localparam int DRAIN_AT     = 900;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_SLACK  = 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int N_DIRECTED   = 26;

	// A stepped date-time together with its month-lookup error flag.
	typedef struct packed {
		date_t stamp;
		logic  bad;
	} stepped_t;

	// One row of the directed table; rows without a typed result use the stepper model.
	typedef struct {
		op_t   code;
		date_t stamp;
		bit    typed;
		date_t want_stamp;
		logic  want_bad;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [15:0] year_in = '0;
	logic [3:0]  month_in = '0;
	logic [4:0]  day_in = '0;
	logic [4:0]  hour_in = '0;
	logic [5:0]  minute_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic        bad_month;

	stepped_t pending_dates[$];
	int       mismatches = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	logic     hold_req = 1'b0;
	logic     hold_taken = 1'b0;
	int       hold_left = 0;
	int       stall_mode = 0;
	int       mode_left = 0;

	calendar_minute_hour_day_stepper u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.year_in    (year_in),
		.month_in   (month_in),
		.day_in     (day_in),
		.hour_in    (hour_in),
		.minute_in  (minute_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.year_out   (year_out),
		.month_out  (month_out),
		.day_out    (day_out),
		.hour_out   (hour_out),
		.minute_out (minute_out),
		.bad_month  (bad_month)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic date_t ymdhm(int y, int mo, int d, int h, int mi);
		date_t r;
		r.year   = 16'(y);
		r.month  = 4'(mo);
		r.day    = 5'(d);
		r.hour   = 5'(h);
		r.minute = 6'(mi);
		return r;
	endfunction

	// Length of a month in days under the Gregorian leap rule; zero for an invalid month.
	function automatic int unsigned month_length(logic [15:0] yr, int unsigned mo);
		bit leap;
		leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
		case (mo)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Steps one date-time; carries and borrows ripple upward through flags in unit order.
	function automatic stepped_t step_date(op_t code, date_t src);
		logic [15:0] yr;
		int unsigned mo, dy, hr, mi, len;
		bit          hour_up, hour_dn, day_up, day_dn, mon_up, mon_dn, refill_day, ok;
		stepped_t    res;
		yr = src.year;
		mo = src.month;
		dy = src.day;
		hr = src.hour;
		mi = src.minute;
		{hour_up, hour_dn, day_up, day_dn, mon_up, mon_dn, refill_day} = '0;
		ok = 1'b1;
		case (code)
			OP_MIN_NEXT: begin
				if (mi >= 59) begin
					mi -= 59;
					hour_up = 1'b1;
				end else begin
					mi++;
				end
			end
			OP_MIN_PREV: begin
				if (mi == 0) begin
					mi = 59;
					hour_dn = 1'b1;
				end else begin
					mi--;
				end
			end
			OP_HOUR_NEXT: hour_up = 1'b1;
			OP_HOUR_PREV: hour_dn = 1'b1;
			OP_DAY_NEXT:  day_up = 1'b1;
			OP_DAY_PREV:  day_dn = 1'b1;
			OP_MON_NEXT:  mon_up = 1'b1;
			default:      mon_dn = 1'b1;
		endcase
		// Hour rollover feeds the day.
		if (hour_up) begin
			if (hr >= 23) begin
				hr -= 23;
				day_up = 1'b1;
			end else begin
				hr++;
			end
		end
		if (hour_dn) begin
			if (hr == 0) begin
				hr = 23;
				day_dn = 1'b1;
			end else begin
				hr--;
			end
		end
		// A forward day step needs the current month's length.
		if (day_up) begin
			len = month_length(yr, mo);
			if (len == 0) begin
				ok = 1'b0;
			end else if (dy >= len) begin
				dy -= len - 1;
				mon_up = 1'b1;
			end else begin
				dy++;
			end
		end
		// A backward day borrow needs the length of the month it lands in.
		if (day_dn) begin
			if (dy <= 1) begin
				mon_dn = 1'b1;
				refill_day = 1'b1;
			end else begin
				dy--;
			end
		end
		if (mon_up) begin
			if (mo >= 12) begin
				mo -= 11;
				yr++;
			end else begin
				mo++;
			end
		end
		if (mon_dn) begin
			if (mo <= 1) begin
				mo += 11;
				yr--;
			end else begin
				mo--;
			end
		end
		if (refill_day) begin
			len = month_length(yr, mo);
			if (len == 0) begin
				ok = 1'b0;
			end else begin
				dy += len - 1;
			end
		end
		res.stamp = ok ? {yr, mo[3:0], dy[4:0], hr[4:0], mi[5:0]} : src;
		res.bad   = !ok;
		return res;
	endfunction

	// Calendar edges, month-length lookups that fail, and extremes of every field.
	vector_t directed_vectors [N_DIRECTED] = '{
		'{OP_MIN_NEXT,  ymdhm(2023, 12, 31, 23, 59), 1'b1, ymdhm(2024, 1, 1, 0, 0), 1'b0},
		'{OP_MIN_PREV,  ymdhm(2024, 1, 1, 0, 0), 1'b1, ymdhm(2023, 12, 31, 23, 59), 1'b0},
		'{OP_MIN_NEXT,  ymdhm(65535, 12, 31, 23, 59), 1'b1, ymdhm(0, 1, 1, 0, 0), 1'b0},
		'{OP_MIN_PREV,  ymdhm(0, 1, 1, 0, 0), 1'b1, ymdhm(65535, 12, 31, 23, 59), 1'b0},
		'{OP_HOUR_NEXT, ymdhm(2024, 2, 28, 23, 10), 1'b0, '0, 1'b0},
		'{OP_HOUR_NEXT, ymdhm(1900, 2, 28, 23, 10), 1'b0, '0, 1'b0},
		'{OP_DAY_NEXT,  ymdhm(2000, 2, 28, 5, 30), 1'b0, '0, 1'b0},
		'{OP_DAY_PREV,  ymdhm(2000, 3, 1, 5, 30), 1'b0, '0, 1'b0},
		'{OP_DAY_NEXT,  ymdhm(2021, 0, 15, 10, 20), 1'b1, ymdhm(2021, 0, 15, 10, 20), 1'b1},
		'{OP_DAY_NEXT,  ymdhm(2021, 13, 15, 10, 20), 1'b1, ymdhm(2021, 13, 15, 10, 20), 1'b1},
		'{OP_DAY_PREV,  ymdhm(2021, 14, 1, 10, 20), 1'b1, ymdhm(2021, 14, 1, 10, 20), 1'b1},
		'{OP_DAY_PREV,  ymdhm(2021, 3, 0, 8, 8), 1'b0, '0, 1'b0},
		'{OP_DAY_PREV,  ymdhm(2021, 0, 5, 8, 8), 1'b0, '0, 1'b0},
		'{OP_MON_NEXT,  ymdhm(2021, 15, 31, 12, 0), 1'b1, ymdhm(2022, 4, 31, 12, 0), 1'b0},
		'{OP_MON_PREV,  ymdhm(2021, 0, 31, 12, 0), 1'b1, ymdhm(2020, 11, 31, 12, 0), 1'b0},
		'{OP_MON_NEXT,  ymdhm(2021, 12, 5, 1, 2), 1'b0, '0, 1'b0},
		'{OP_MON_PREV,  ymdhm(2021, 1, 5, 1, 2), 1'b0, '0, 1'b0},
		'{OP_HOUR_NEXT, ymdhm(2021, 6, 10, 31, 0), 1'b0, '0, 1'b0},
		'{OP_MIN_NEXT,  ymdhm(2021, 6, 10, 5, 63), 1'b0, '0, 1'b0},
		'{OP_DAY_NEXT,  ymdhm(2021, 4, 31, 7, 7), 1'b0, '0, 1'b0},
		'{OP_HOUR_PREV, ymdhm(2100, 3, 1, 0, 45), 1'b0, '0, 1'b0},
		'{OP_DAY_NEXT,  ymdhm(2100, 2, 29, 3, 3), 1'b0, '0, 1'b0},
		'{OP_MIN_PREV,  ymdhm(0, 0, 0, 0, 0), 1'b0, '0, 1'b0},
		'{OP_MON_PREV,  ymdhm(65535, 15, 31, 31, 63), 1'b1, ymdhm(65535, 14, 31, 31, 63), 1'b0},
		'{OP_MIN_NEXT,  ymdhm(65535, 15, 31, 31, 63), 1'b1, ymdhm(65535, 15, 31, 31, 63), 1'b1},
		'{OP_MON_PREV,  ymdhm(0, 1, 15, 9, 9), 1'b1, ymdhm(65535, 12, 15, 9, 9), 1'b0}
	};

	// Offers one input transaction and records its expected result once it is accepted.
	task automatic offer_item(input op_t code, input date_t stamp, input bit typed,
			input stepped_t want);
		in_valid  <= 1'b1;
		op        <= code;
		year_in   <= stamp.year;
		month_in  <= stamp.month;
		day_in    <= stamp.day;
		hour_in   <= stamp.hour;
		minute_in <= stamp.minute;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_dates.push_back(typed ? want : step_date(code, stamp));
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Bursts of random length separated by random gaps, some of them empty.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Mostly well-formed date-times biased to rollover edges, plus broken fields and raw noise.
	task automatic pick_item(output op_t code, output date_t stamp);
		int unsigned kind, len;
		int unsigned edge_years [8] = '{0, 1600, 1900, 2000, 2023, 2024, 2100, 65535};
		code = op_t'($urandom_range(0, 7));
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			stamp.year   = 16'($urandom);
			stamp.month  = 4'($urandom);
			stamp.day    = 5'($urandom);
			stamp.hour   = 5'($urandom);
			stamp.minute = 6'($urandom);
		end else begin
			stamp.year = $urandom_range(0, 1) ? 16'($urandom)
				: 16'(edge_years[$urandom_range(0, 7)]);
			if ($urandom_range(0, 3) == 0) begin
				stamp.month = $urandom_range(0, 1) ? 4'd12 : 4'd1;
			end else begin
				stamp.month = 4'($urandom_range(1, 12));
			end
			len = month_length(stamp.year, stamp.month);
			case ($urandom_range(0, 3))
				0:       stamp.day = 5'd1;
				1:       stamp.day = 5'(len);
				2:       stamp.day = 5'(len - 1);
				default: stamp.day = 5'($urandom_range(1, len));
			endcase
			case ($urandom_range(0, 2))
				0:       stamp.hour = 5'd0;
				1:       stamp.hour = 5'd23;
				default: stamp.hour = 5'($urandom_range(0, 23));
			endcase
			case ($urandom_range(0, 2))
				0:       stamp.minute = 6'd0;
				1:       stamp.minute = 6'd59;
				default: stamp.minute = 6'($urandom_range(0, 59));
			endcase
			// Break one field of an otherwise well-formed date-time.
			if (kind < 6) begin
				case ($urandom_range(0, 3))
					0:       stamp.month = 4'($urandom_range(13, 16) % 16);
					1:       stamp.day = $urandom_range(0, 1) ? 5'd0
						: 5'($urandom_range(28, 31));
					2:       stamp.hour = 5'($urandom_range(24, 31));
					default: stamp.minute = 6'($urandom_range(60, 63));
				endcase
			end
		end
	endtask

	// Main stimulus: reset, directed table, then the random part with a flood and a drain.
	initial begin
		op_t   code;
		date_t stamp;
		int    flood_left;
		flood_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			offer_item(directed_vectors[i].code, directed_vectors[i].stamp,
				directed_vectors[i].typed,
				{directed_vectors[i].want_stamp, directed_vectors[i].want_bad});
			pace_sender();
		end
		wait_drained();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == FLOOD_AT) begin
				hold_req <= 1'b1;
				flood_left = FLOOD_ITEMS;
			end
			if (i == DRAIN_AT) begin
				wait_drained();
			end
			pick_item(code, stamp);
			offer_item(code, stamp, 1'b0, '0);
			if (flood_left > 0) begin
				flood_left--;
			end else begin
				pace_sender();
			end
		end
		wait_drained();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Receiver stall pattern: one long hold on request, otherwise changing random modes.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= LONG_HOLD;
			out_stall  <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				2:       out_stall <= ~out_stall;
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Each accepted result transaction is compared with the oldest expectation.
	always @(posedge clk) begin : result_monitor
		stepped_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dates.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				check_field("year_out", want.stamp.year, year_out);
				check_field("month_out", want.stamp.month, month_out);
				check_field("day_out", want.stamp.day, day_out);
				check_field("hour_out", want.stamp.hour, hour_out);
				check_field("minute_out", want.stamp.minute, minute_out);
				check_field("bad_month", want.bad, bad_month);
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
